// ----- src/xpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package xpp_pkg;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  localparam int unsigned ROT_OUT   = 23;
  localparam int unsigned SHL_STATE = 17;
  localparam int unsigned ROT_STATE = 45;
  localparam int unsigned SHR_MIX0  = 30;
  localparam int unsigned SHR_MIX1  = 27;
  localparam int unsigned SHR_MIX2  = 31;

  localparam int unsigned NUM_WORDS = 4;

  localparam logic MODE_SEED = 1'b0;
  localparam logic MODE_NEXT = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD,
    OP_MUL_LL,
    OP_MUL_LH,
    OP_MUL_HL,
    OP_MIX,
    OP_FIN,
    OP_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       csel;   // 0: first mix multiplier, 1: second
    logic [1:0] word;   // state word written on OP_FIN
  } dp_cmd_t;

  typedef struct packed {
    logic out_hold;     // result register is full and not taken this cycle
  } dp_status_t;

endpackage
`default_nettype wire

// ----- src/xpp_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface xpp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] seed_value;

  modport source (output valid, output mode, output seed_value, input ready);
  modport sink (input valid, input mode, input seed_value, output ready);
endinterface
`default_nettype wire

// ----- src/xpp_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface xpp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface
`default_nettype wire

// ----- src/xoshiro256pp_prng_with_seeding_core.sv -----
// Next item: result valid in the cycle after its transfer; one next item per cycle while
//   the output side keeps up (the result register frees in the cycle it is taken).
// Seed item: after its transfer, 4 rounds x 9 steps through one shared 32x32 multiplier,
//   three partial products per 64-bit multiply; no result, ready low meanwhile.
// Reset (rst_n low, synchronous): state words zero, result register empty, controller idle.
`timescale 1ns / 1ps
`default_nettype none
module xoshiro256pp_prng_with_seeding_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  xpp_in_if.sink      in_if,
  xpp_out_if.source   out_if
);

  xpp_pkg::dp_cmd_t    cmd;
  xpp_pkg::dp_status_t stat;
  logic                in_ready;

  // Controller sequences the seed rounds and decides when a transfer is taken.
  xpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_mode  (in_if.mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_if.ready = in_ready;

  // Datapath holds the generator words, the mix registers and the result register.
  xpp_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .seed_value   (in_if.seed_value),
    .stat         (stat),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .random_value (out_if.random_value)
  );

endmodule
`default_nettype wire

// ----- src/xpp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module xpp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_mode,
  output logic                    in_ready,
  input  wire xpp_pkg::dp_status_t stat,
  output xpp_pkg::dp_cmd_t        cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_MA0,
    S_MA1,
    S_MA2,
    S_MIX,
    S_MB0,
    S_MB1,
    S_MB2,
    S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] round_r, round_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE) && !stat.out_hold;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    cmd.op    = xpp_pkg::OP_NONE;
    cmd.csel  = 1'b0;
    cmd.word  = round_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == xpp_pkg::MODE_SEED) begin
            cmd.op    = xpp_pkg::OP_LOAD;
            state_nxt = S_ADD;
            round_nxt = 2'd0;
          end else begin
            cmd.op = xpp_pkg::OP_NEXT;
          end
        end
      end
      S_ADD: begin
        cmd.op    = xpp_pkg::OP_ADD;
        state_nxt = S_MA0;
      end
      S_MA0: begin
        cmd.op    = xpp_pkg::OP_MUL_LL;
        state_nxt = S_MA1;
      end
      S_MA1: begin
        cmd.op    = xpp_pkg::OP_MUL_LH;
        state_nxt = S_MA2;
      end
      S_MA2: begin
        cmd.op    = xpp_pkg::OP_MUL_HL;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.op    = xpp_pkg::OP_MIX;
        state_nxt = S_MB0;
      end
      S_MB0: begin
        cmd.op    = xpp_pkg::OP_MUL_LL;
        cmd.csel  = 1'b1;
        state_nxt = S_MB1;
      end
      S_MB1: begin
        cmd.op    = xpp_pkg::OP_MUL_LH;
        cmd.csel  = 1'b1;
        state_nxt = S_MB2;
      end
      S_MB2: begin
        cmd.op    = xpp_pkg::OP_MUL_HL;
        cmd.csel  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op = xpp_pkg::OP_FIN;
        if (round_r == 2'(xpp_pkg::NUM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          round_nxt = round_r + 2'd1;
          state_nxt = S_ADD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      round_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  a_last_round_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && (round_r == 2'(xpp_pkg::NUM_WORDS - 1)) |=> (state_r == S_IDLE))
    else $error("seeding did not finish after the last round");

  a_seed_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == xpp_pkg::MODE_SEED) |=> (state_r == S_ADD) && (round_r == 2'd0))
    else $error("seed transfer did not start round zero");

  a_next_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == xpp_pkg::MODE_NEXT) |=> (state_r == S_IDLE))
    else $error("next transfer left idle");

endmodule
`default_nettype wire

// ----- src/xpp_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module xpp_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire xpp_pkg::dp_cmd_t    cmd,
  input  wire logic [63:0]         seed_value,
  output xpp_pkg::dp_status_t      stat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [63:0]              random_value
);

  logic [63:0] s_r   [xpp_pkg::NUM_WORDS];
  logic [63:0] s_nxt [xpp_pkg::NUM_WORDS];
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] z_r, z_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [63:0] acc_inc;
  logic [63:0] mul_c;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  logic [63:0] sum03, gen_res, shl_w1;
  logic [63:0] t2, t3;

  assign acc_inc = acc_r + xpp_pkg::GOLDEN_STEP;
  assign mul_c   = cmd.csel ? xpp_pkg::MIX_MUL_B : xpp_pkg::MIX_MUL_A;

  // shared 32x32 multiplier; low 64 bits of z * C from three partial products
  always_comb begin
    mul_x = z_r[31:0];
    mul_y = mul_c[31:0];
    case (cmd.op)
      xpp_pkg::OP_MUL_LH: mul_y = mul_c[63:32];
      xpp_pkg::OP_MUL_HL: mul_x = z_r[63:32];
      default: ;
    endcase
  end
  assign mul_p = 64'(mul_x) * 64'(mul_y);

  assign sum03   = s_r[0] + s_r[3];
  assign gen_res = s_r[0] + {sum03[63-xpp_pkg::ROT_OUT:0], sum03[63:64-xpp_pkg::ROT_OUT]};
  assign shl_w1  = s_r[1] << xpp_pkg::SHL_STATE;
  assign t2      = s_r[2] ^ s_r[0];
  assign t3      = s_r[3] ^ s_r[1];

  always_comb begin
    for (int i = 0; i < xpp_pkg::NUM_WORDS; i++) begin
      s_nxt[i] = s_r[i];
    end
    acc_nxt       = acc_r;
    z_nxt         = z_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (cmd.op)
      xpp_pkg::OP_LOAD: acc_nxt = seed_value;
      xpp_pkg::OP_ADD: begin
        acc_nxt = acc_inc;
        z_nxt   = acc_inc ^ (acc_inc >> xpp_pkg::SHR_MIX0);
      end
      xpp_pkg::OP_MUL_LL: prod_nxt = mul_p;
      xpp_pkg::OP_MUL_LH,
      xpp_pkg::OP_MUL_HL: prod_nxt = prod_r + {mul_p[31:0], 32'd0};
      xpp_pkg::OP_MIX: z_nxt = prod_r ^ (prod_r >> xpp_pkg::SHR_MIX1);
      xpp_pkg::OP_FIN: s_nxt[cmd.word] = prod_r ^ (prod_r >> xpp_pkg::SHR_MIX2);
      xpp_pkg::OP_NEXT: begin
        out_data_nxt  = gen_res;
        out_valid_nxt = 1'b1;
        s_nxt[0] = s_r[0] ^ t3;
        s_nxt[1] = s_r[1] ^ t2;
        s_nxt[2] = t2 ^ shl_w1;
        s_nxt[3] = {t3[63-xpp_pkg::ROT_STATE:0], t3[63:64-xpp_pkg::ROT_STATE]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < xpp_pkg::NUM_WORDS; i++) begin
        s_r[i] <= 64'd0;
      end
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < xpp_pkg::NUM_WORDS; i++) begin
        s_r[i] <= s_nxt[i];
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    z_r        <= z_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign random_value  = out_data_r;
  assign stat.out_hold = out_valid_r && !out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == xpp_pkg::OP_NEXT) |-> (!out_valid_r || out_ready))
    else $error("new result would overwrite a pending one");

  a_next_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == xpp_pkg::OP_NEXT) |=> out_valid_r && (out_data_r == $past(gen_res)))
    else $error("generated value not presented");

  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result changed before its transfer");

endmodule
`default_nettype wire
